// ===== hdl/mec_pkg.sv =====
// Package for the median / moving-average distance filter.
// Holds the window and queue sizes, derived widths and the queue entry types.
// No dependencies.
package mec_pkg;

	// Sample window length and the widths that follow from it.
	localparam int WINDOW_SIZE = 5;
	localparam int SLOT_W      = $clog2(WINDOW_SIZE);
	localparam int RANK_W      = $clog2(WINDOW_SIZE);
	localparam logic [RANK_W-1:0] MID_RANK = RANK_W'(WINDOW_SIZE / 2);

	// Fixed field widths.
	localparam int DATA_W = 16;
	localparam int FRAC_W = 16;
	localparam int AVG_W  = DATA_W + FRAC_W;
	localparam int PROD_W = 2 * DATA_W;
	localparam int SUM_W  = AVG_W + FRAC_W + 1;

	// Reset weight of the new median, 0.15 in Q0.16.
	localparam logic [DATA_W-1:0] EMA_WEIGHT_RESET = 16'd9830;

	// Queue between the front and back ends.
	localparam int Q_DEPTH = 4;
	localparam int QPTR_W  = $clog2(Q_DEPTH);
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	// One classified word: raw sample while warming, else the window median.
	typedef struct packed {
		logic              warm;
		logic [DATA_W-1:0] value;
	} mec_entry_t;

	// Head of the queue as seen by the back end.
	typedef struct packed {
		logic       valid;
		mec_entry_t entry;
	} mec_qhead_t;

endpackage

// ===== hdl/mec_front.sv =====
// Front end: accepts samples, keeps the sample ring and classifies each word.
// Pushes the raw sample or the window median into the queue. Uses mec_pkg.
module mec_front import mec_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [DATA_W-1:0] sample_distance,
	input  logic [QCNT_W-1:0] q_count,
	output logic              push,
	output mec_entry_t        push_entry
);

	logic [DATA_W-1:0] ring_q [WINDOW_SIZE];
	logic [SLOT_W-1:0] slot_q;
	logic              full_q;
	logic              valid_s1;
	logic              warm_s1;
	logic [DATA_W-1:0] raw_s1;
	logic              accept;
	logic              last_slot;
	logic [QCNT_W-1:0] q_level;
	logic [DATA_W-1:0] median;
	logic [RANK_W-1:0] rank;

	// Room is counted for the word already in the classify stage.
	assign q_level  = q_count + QCNT_W'(valid_s1);
	assign in_ready = (q_level < QCNT_W'(Q_DEPTH));
	assign accept   = in_valid && in_ready;
	assign last_slot = (slot_q == SLOT_W'(WINDOW_SIZE - 1));

	// Control state: ring position, fill flag and the classify stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q   <= '0;
			full_q   <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (last_slot) begin
					slot_q <= '0;
					full_q <= 1'b1;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
		end
	end

	// Ring write and the stage payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			ring_q[slot_q] <= sample_distance;
			raw_s1         <= sample_distance;
			warm_s1        <= !(full_q || last_slot);
		end
	end

	// Median by rank: each entry counts the entries that sort before it,
	// ties broken by position, and the one of middle rank is picked.
	// The ring registers hold exactly the window of the word in the stage.
	always_comb begin
		median = '0;
		rank   = '0;
		for (int i = 0; i < WINDOW_SIZE; i++) begin
			rank = '0;
			for (int j = 0; j < WINDOW_SIZE; j++) begin
				if (j != i) begin
					if ((ring_q[j] < ring_q[i]) || ((ring_q[j] == ring_q[i]) && (j < i))) begin
						rank = rank + 1'b1;
					end
				end
			end
			if (rank == MID_RANK) begin
				median = ring_q[i];
			end
		end
	end

	assign push             = valid_s1;
	assign push_entry.warm  = warm_s1;
	assign push_entry.value = warm_s1 ? raw_s1 : median;

`ifndef SYNTH
	a_accept_stages: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted word did not reach the classify stage");
	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(full_q))
		else $error("window full flag cleared after filling");
`endif

endmodule

// ===== hdl/mec_queue.sv =====
// Short queue between the front and back ends of the distance filter.
// Register array with head and tail pointers and a fill count. Uses mec_pkg.
module mec_queue import mec_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mec_entry_t        push_entry,
	input  logic              pop,
	output mec_qhead_t        head,
	output logic [QCNT_W-1:0] count
);

	mec_entry_t        mem_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// Pointer and count update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	assign head.valid = (count_q != '0);
	assign head.entry = mem_q[rd_ptr_q];
	assign count      = count_q;

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(Q_DEPTH))
		else $error("queue count beyond depth");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> (count_q < QCNT_W'(Q_DEPTH)))
		else $error("push into a full queue");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("pop from an empty queue");
`endif

endmodule

// ===== hdl/mec_back.sv =====
// Back end: weight product, moving-average update and the output register.
// Holds the weight register and the Q16.16 average. Uses mec_pkg.
module mec_back import mec_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [DATA_W-1:0] cfg_wr_data,
	input  mec_qhead_t        head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] smoothed_distance,
	output logic              warming_up
);

	logic [DATA_W-1:0] weight_q;
	logic [AVG_W-1:0]  avg_q;
	logic              seeded_q;
	logic              valid_s1;
	logic              valid_s2;
	logic              valid_s3;
	logic              warm_s1;
	logic              warm_s2;
	logic              warm_s3;
	logic [DATA_W-1:0] value_s1;
	logic [DATA_W-1:0] value_s2;
	logic [PROD_W-1:0] product_s1;
	logic [DATA_W-1:0] filt_s3;
	logic              adv;
	logic [DATA_W:0]   inv_weight;
	logic [SUM_W-1:0]  keep_prod;
	logic [SUM_W-1:0]  sum;
	logic [AVG_W-1:0]  next_avg;
	logic [AVG_W:0]    round_sum;
	logic [DATA_W-1:0] rounded;

	// The pipe moves whenever the output register is free or being taken.
	assign adv = !valid_s3 || out_ready;
	assign pop = adv && head.valid;

	// Average update: (w*M<<16 + (1-w)*A + half) >> 16, kept to 32 bits.
	assign inv_weight = (DATA_W + 1)'(1 << FRAC_W) - {1'b0, weight_q};
	assign keep_prod  = {{(SUM_W - DATA_W - 1){1'b0}}, inv_weight}
		* {{(SUM_W - AVG_W){1'b0}}, avg_q};
	assign sum = {1'b0, product_s1, {FRAC_W{1'b0}}}
		+ keep_prod
		+ SUM_W'(1 << (FRAC_W - 1));
	assign next_avg = sum[AVG_W+FRAC_W-1:FRAC_W];

	// Output rounding of the average, saturated to the field range.
	assign round_sum = {1'b0, avg_q} + (AVG_W + 1)'(1 << (FRAC_W - 1));
	assign rounded = round_sum[AVG_W] ? '1 : round_sum[AVG_W-1:FRAC_W];

	// Control state, weight and the average.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= EMA_WEIGHT_RESET;
			avg_q    <= '0;
			seeded_q <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				weight_q <= cfg_wr_data;
			end
			if (adv) begin
				valid_s1 <= head.valid;
				valid_s2 <= valid_s1;
				valid_s3 <= valid_s2;
				// The first median seeds the average, which then equals it exactly.
				if (valid_s1 && !warm_s1) begin
					avg_q    <= seeded_q ? next_avg : {value_s1, {FRAC_W{1'b0}}};
					seeded_q <= 1'b1;
				end
			end
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			warm_s1    <= head.entry.warm;
			value_s1   <= head.entry.value;
			product_s1 <= weight_q * head.entry.value;
			warm_s2    <= warm_s1;
			value_s2   <= value_s1;
			warm_s3    <= warm_s2;
			filt_s3    <= warm_s2 ? value_s2 : rounded;
		end
	end

	assign out_valid         = valid_s3;
	assign smoothed_distance = filt_s3;
	assign warming_up        = warm_s3;

`ifndef SYNTH
	a_seed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(seeded_q))
		else $error("average seed flag cleared");
	a_seeded_before_use: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !warm_s2) |-> seeded_q)
		else $error("average used before it was seeded");
`endif

endmodule

// ===== hdl/median_ema_cascade_filter.sv =====
// Top level of the median-of-window / moving-average distance filter.
// Connects mec_front, mec_queue and mec_back. Uses mec_pkg.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------
//   input   | in        | in_valid / in_ready  | sample_distance
//   output  | out       | out_valid / out_ready| smoothed_distance, warming_up
//   config  | in        | cfg_wr_en            | cfg_wr_data (ema_weight)
//
// One word is accepted per cycle while in_ready is high; each result passes through
// one classify stage, the queue and three back-end stages. The average update is
// one multiply-add per cycle while the back-end pipe advances.
// Reset clears the ring position, fill flag, average, seed flag and queue; the
// weight returns to 0.15. in_ready drops once the queue and the classify stage
// together hold four words, so a stalled output still fills the four-entry queue.
module median_ema_cascade_filter import mec_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [DATA_W-1:0] sample_distance,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] smoothed_distance,
	output logic              warming_up,
	input  logic              cfg_wr_en,
	input  logic [DATA_W-1:0] cfg_wr_data
);

	logic              push;
	mec_entry_t        push_entry;
	logic              pop;
	mec_qhead_t        head;
	logic [QCNT_W-1:0] q_count;

	mec_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.sample_distance (sample_distance),
		.q_count         (q_count),
		.push            (push),
		.push_entry      (push_entry)
	);

	mec_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.count      (q_count)
	);

	mec_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_wr_data       (cfg_wr_data),
		.head              (head),
		.pop               (pop),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.smoothed_distance (smoothed_distance),
		.warming_up        (warming_up)
	);

endmodule
